// File: design/swmv_pkg.sv
// Package for the sliding window mean and variance block.
// Holds payload structs, sizing constants and action codes; no dependencies.
package swmv_pkg;

  localparam int WINDOW_DEFAULT = 32;

  // Action codes for the input transaction.
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [33:0] VAR_MAX = 34'h3_FFFF_FFFF;

  typedef struct packed {
    logic               action;
    logic signed [15:0] sample;
  } swmv_in_t;

  typedef struct packed {
    logic        [5:0]  count;
    logic               window_full;
    logic signed [23:0] mean_value;
    logic        [33:0] variance_value;
    logic        [23:0] std_deviation;
  } swmv_out_t;

endpackage

// File: design/sliding_window_mean_variance_top.sv
// Sliding window mean, variance and standard deviation, top level.
// Uses swmv_pkg, swmv_mul, swmv_divider and swmv_sqrt.
//
// Usage:
//   Input channel in_valid / in_stall carries swmv_in_t: a push of one signed
//   sample, or a clear of all statistics. Output channel out_valid /
//   out_stall carries one swmv_out_t transaction per input transaction.
//   One item is worked on at a time; in_stall is high from acceptance until
//   its result has been taken.
//   Steps: a push reads the ring and updates the sums, then runs two serial
//   products S*S and n*Q, a 64-bit serial division of n*Q-S*S by n*(n-1)
//   and one for the 16-bit fraction, a 24-bit square root and a 64-bit
//   division for the mean, after which out_valid rises. With one sample
//   held the variance division and square root are skipped; a clear
//   answers on the next cycle.
//   The next input can be taken in the cycle after the result leaves.
//   A stall on the output simply holds the result register.
//   Reset (rst, synchronous) clears the count, sums and control; the ring
//   contents stay undefined until written and are used only once full.
module sliding_window_mean_variance_top
  import swmv_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  swmv_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output swmv_out_t out_data
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int NW = $clog2(WINDOW + 1);
  localparam int SW = 16 + NW;
  localparam int QW = 30 + NW;
  localparam int DW = 2 * NW;
  localparam int PW = QW + SW;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_UPD, S_MSQ, S_MNQ, S_VDIV, S_VFRAC, S_SQRT, S_MDIV, S_OUT
  } state_t;

  state_t state;

  logic signed [15:0] ring [WINDOW];
  logic signed [15:0] old_smp;
  logic signed [15:0] cur_smp;
  logic [AW-1:0]      write_slot;
  logic [NW-1:0]      held_count;
  logic               full_flag;
  logic signed [SW-1:0] running_sum;
  logic [QW-1:0]      running_square_sum;

  logic [63:0] var_num;
  logic [63:0] vq;
  logic [DW-1:0] vr;
  logic [DW-1:0] den;
  logic [33:0] var_q4;
  logic [23:0] sd;
  logic signed [23:0] mean_r;

  // Shared serial units.
  logic        mul_start, mul_done;
  logic [QW-1:0] mul_a;
  logic [SW-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic        div_start, div_done;
  logic [63:0] div_n;
  logic [DW-1:0] div_d;
  logic [63:0] div_q;
  logic [DW-1:0] div_r;
  logic        sq_start, sq_done;
  logic [47:0] sq_in;
  logic [23:0] sq_root;
  logic [63:0] ss_val;
  logic        mean_neg;
  logic [SW-1:0] abs_sum;

  swmv_mul #(.AW(QW), .BW(SW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  swmv_divider #(.NW(64), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_n), .denom(div_d),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  swmv_sqrt #(.RW(24)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root)
  );

  assign in_stall = (state != S_IDLE);
  assign abs_sum  = $unsigned(running_sum[SW-1] ? -running_sum : running_sum);

  // Ring read and write in a clocked block.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      old_smp <= ring[write_slot];
    end
    if (state == S_UPD) begin
      ring[write_slot] <= cur_smp;
    end
  end

  // Control and datapath sequencing.
  always_ff @(posedge clk) begin
    mul_start <= 1'b0;
    div_start <= 1'b0;
    sq_start  <= 1'b0;
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      write_slot         <= '0;
      held_count         <= '0;
      full_flag          <= 1'b0;
      running_sum        <= '0;
      running_square_sum <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_smp <= in_data.sample;
            if (in_data.action == ACT_CLEAR) begin
              write_slot         <= '0;
              held_count         <= '0;
              full_flag          <= 1'b0;
              running_sum        <= '0;
              running_square_sum <= '0;
              mean_r             <= '0;
              var_q4             <= '0;
              sd                 <= '0;
              state              <= S_OUT;
              out_valid          <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_UPD;
        end
        S_UPD: begin
          // Sums stay exact; the square-sum add and subtract fit in QW bits.
          if (full_flag) begin
            running_sum <= running_sum + SW'(cur_smp) - SW'(old_smp);
            running_square_sum <= running_square_sum
                                  + QW'($unsigned(32'(cur_smp) * 32'(cur_smp)))
                                  - QW'($unsigned(32'(old_smp) * 32'(old_smp)));
          end else begin
            running_sum <= running_sum + SW'(cur_smp);
            running_square_sum <= running_square_sum
                                  + QW'($unsigned(32'(cur_smp) * 32'(cur_smp)));
            held_count <= held_count + 1'b1;
            if (32'(held_count) + 1 >= WINDOW) begin
              full_flag <= 1'b1;
            end
          end
          write_slot <= (32'(write_slot) == WINDOW - 1) ? '0 : write_slot + 1'b1;
          state <= S_MSQ;
          mul_start <= 1'b1;
        end
        S_MSQ: begin
          // S*S, then n*Q.
          if (mul_done) begin
            ss_val    <= 64'(mul_p);
            mul_start <= 1'b1;
            state     <= S_MNQ;
          end
        end
        S_MNQ: begin
          if (mul_done) begin
            var_num <= 64'(mul_p) - ss_val;
            den     <= DW'(held_count) * DW'(held_count - 1'b1);
            if (held_count > NW'(1)) begin
              div_start <= 1'b1;
              state     <= S_VDIV;
            end else begin
              var_q4    <= '0;
              sd        <= '0;
              div_start <= 1'b1;
              state     <= S_MDIV;
            end
          end
        end
        S_VDIV: begin
          // Integer quotient; then the 16-bit fraction r*65536/den.
          if (div_done) begin
            vq        <= div_q;
            vr        <= div_r;
            div_start <= 1'b1;
            state     <= S_VFRAC;
          end
        end
        S_VFRAC: begin
          if (div_done) begin
            if (vq[63:30] != '0) begin
              var_q4 <= VAR_MAX;
            end else begin
              var_q4 <= {vq[29:0], div_q[15:12]};
            end
            sq_start <= 1'b1;
            state    <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            sd        <= sq_root;
            div_start <= 1'b1;
            state     <= S_MDIV;
          end
        end
        S_MDIV: begin
          // Mean magnitude |S|*256/n, sign restored, truncation toward zero.
          if (div_done) begin
            mean_r    <= mean_neg ? -div_q[23:0] : div_q[23:0];
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operand selection for the shared units; each unit takes its operands
  // in the first cycle of the state that starts it.
  always_comb begin
    mean_neg = running_sum[SW-1];
    if (state == S_MNQ) begin
      mul_a = running_square_sum;
      mul_b = SW'(held_count);
    end else begin
      mul_a = QW'(abs_sum);
      mul_b = abs_sum;
    end
    if (state == S_VDIV) begin
      div_n = var_num;
      div_d = den;
    end else if (state == S_VFRAC) begin
      div_n = 64'({vr, 16'h0000});
      div_d = den;
    end else begin
      div_n = 64'({abs_sum, 8'h00});
      div_d = DW'(held_count);
    end
    sq_in = {vq[31:0], div_q[15:0]};
  end

  // Result assembly.
  always_comb begin
    out_data.count          = 6'(held_count);
    out_data.window_full    = full_flag;
    out_data.mean_value     = (held_count == '0) ? '0 : mean_r;
    out_data.variance_value = var_q4;
    out_data.std_deviation  = sd;
  end

endmodule

// File: design/swmv_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nothing beyond its own parameters.
module swmv_divider #(
  parameter int NW = 64,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW-1:0] den;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // One shift-and-subtract step on the partial remainder.
  assign trial = {rem, quot[NW-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      quot <= numer;
      rem  <= '0;
      den  <= denom;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem  <= diff[DW-1:0];
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem  <= trial[DW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: design/swmv_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on nothing beyond its own parameter.
module swmv_sqrt #(
  parameter int RW = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CW = $clog2(RW + 1);

  logic [CW-1:0]   cnt;
  logic            busy;
  logic [2*RW-1:0] rad;
  logic [RW+1:0]   part;
  logic [RW+1:0]   trial;
  logic [RW+1:0]   test;

  // Bring down two radicand bits and try the next root bit.
  assign trial = {part[RW-1:0], rad[2*RW-1:2*RW-2]};
  assign test  = {root, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(RW);
      rad  <= radicand;
      part <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*RW-3:0], 2'b00};
      if (trial >= test) begin
        part <= trial - test;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        part <= trial;
        root <= {root[RW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: design/swmv_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing beyond its own parameters.
module swmv_mul #(
  parameter int AW = 40,
  parameter int BW = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [AW+BW-1:0] mcand;
  logic [BW-1:0]    mplier;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      cnt    <= CW'(BW);
      mcand  <= (AW+BW)'(a);
      mplier <= b;
      prod   <= '0;
    end else if (busy) begin
      // Add the shifted multiplicand where the current bit is set.
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= {mcand[AW+BW-2:0], 1'b0};
      mplier <= mplier >> 1;
      cnt    <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: design/swmv_checker.sv
// Port-level checker for the sliding window block, with its bind.
// Depends on swmv_pkg.
module swmv_port_checker
  import swmv_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input swmv_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input swmv_out_t out_data
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // While a result waits, no input is taken.
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted with result pending");

  // Variance and deviation are zero below two samples.
  a_small: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.count < 6'd2 |->
      out_data.variance_value == '0 && out_data.std_deviation == '0)
    else $error("nonzero variance with fewer than two samples");

  // A clear yields an empty window.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.action == ACT_CLEAR |=>
      out_valid && out_data.count == '0 && !out_data.window_full)
    else $error("clear did not empty the window");

endmodule

bind sliding_window_mean_variance_top swmv_port_checker u_swmv_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
